### sv/tic_pkg.sv
// Shared types, widths and constants for the table interpolation unit.
`default_nettype none
package tic_pkg;

  // default number of table slots
  localparam int TABLE_DEPTH_DEF = 256;

  // field widths
  localparam int LEN_W    = 9;   // table_length register
  localparam int ENTRY_W  = 32;  // wavelength and yield words
  localparam int INDEX_W  = 8;   // entry_index field
  localparam int RES_W    = 17;  // interpolated_yield
  localparam int DIFF_W   = ENTRY_W + 1;
  localparam int PROD_W   = 2 * ENTRY_W;
  localparam int QUOT_W   = 35;  // quotient bits kept before saturation
  localparam int VAL_W    = QUOT_W + 2;

  // stream payload layout
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 24;
  localparam int IDX_LSB    = 0;
  localparam int WL_LSB     = 8;
  localparam int YL_LSB     = 40;
  localparam int QW_LSB     = 72;

  // numeric constants
  localparam logic [QUOT_W-1:0]       QUOT_SAT  = QUOT_W'(64'd1 << 34);
  localparam logic signed [VAL_W-1:0] VAL_ONE   = VAL_W'(65536);
  localparam logic [RES_W-1:0]        RES_ONE   = RES_W'(65536);
  localparam logic [LEN_W-1:0]        LEN_RESET = LEN_W'(2);

  // operation codes carried in tuser
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // query sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWAIT,
    ST_RDHI,
    ST_DIFF,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_OUT
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_status_t;

  // magnitude of a difference that stays below 2^32
  function automatic logic [ENTRY_W-1:0] mag33(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] n;
    n = -x;
    return x[DIFF_W-1] ? n[ENTRY_W-1:0] : x[ENTRY_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/tic_table.sv
// Table memory with one write port and one read port, holding wavelength and yield pairs.
`default_nettype none
module tic_table #(
  parameter int DEPTH = tic_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire logic [2*tic_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]              rd_addr,
  output logic      [2*tic_pkg::ENTRY_W-1:0] rd_data
);
  import tic_pkg::*;

  logic [2*ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/tic_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated at 2^34.
`default_nettype none
module tic_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tic_pkg::PROD_W-1:0]    dividend,
  input  wire logic [tic_pkg::ENTRY_W-1:0]   divisor,
  output tic_pkg::div_status_t               status
);
  import tic_pkg::*;

  localparam int HI_W  = PROD_W - QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic                 busy;
  logic                 done;
  logic                 sat;
  logic [CNT_W-1:0]     cnt;
  logic [ENTRY_W-1:0]   rem;
  logic [ENTRY_W-1:0]   dvs;
  logic [QUOT_W-1:0]    shreg;   // dividend bits in, quotient bits out

  logic [ENTRY_W:0]     rem_sh;
  logic                 ge;
  logic [ENTRY_W:0]     rem_sub;
  logic                 sat_c;

  // quotient of 2^35 or more saturates at once
  assign sat_c = ENTRY_W'(dividend[PROD_W-1:QUOT_W]) >= divisor;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, shreg[QUOT_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !sat_c;
        done <= sat_c;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= ENTRY_W'(dividend[PROD_W-1:QUOT_W]);
      shreg <= dividend[QUOT_W-1:0];
      dvs   <= divisor;
      sat   <= sat_c;
    end else if (busy) begin
      rem   <= ge ? rem_sub[ENTRY_W-1:0] : rem_sh[ENTRY_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], ge};
    end
  end

  assign status.done = done;
  assign status.quot = (sat || shreg > QUOT_SAT) ? QUOT_SAT : shreg;

  // HI_W documents the top slice used for the early saturation test
  if (HI_W <= 0) begin : g_bad
    $error("dividend narrower than quotient");
  end

endmodule
`default_nettype wire

### sv/table_interp_clamp_unit_core.sv
// Top level: table loads, binary search sequencer and interpolation datapath.
// Load: writes the table slot, no result, input stays ready. Query: binary search over the
// table, then table reads, subtract and multiply, the divider (skipped when the wavelengths
// are equal) and the result register; no new input is taken until the result is registered.
// A stalled output holds the sequencer until the result register frees.
// rst (synchronous) clears sequencer, output valid, table_length to 2; table not cleared.
`default_nettype none
module table_interp_clamp_unit_core #(
  parameter int TABLE_DEPTH = tic_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration: table_length
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tic_pkg::LEN_W-1:0]         cfg_data,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // entry_index[7:0], entry_wavelength[39:8], entry_yield[71:40],
  // query_wavelength[103:72]
  input  wire logic [tic_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation[0]
  input  wire logic                              s_axis_tuser,
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // interpolated_yield[16:0], zero fill [23:17]
  output logic [tic_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
  import tic_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int NLEN_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [NLEN_W-1:0] N_MAX = NLEN_W'(TABLE_DEPTH);
  localparam logic [NLEN_W-1:0] N_MIN = NLEN_W'(2);

  // payload fields
  logic                 in_op;
  logic [INDEX_W-1:0]   in_idx;
  logic [ENTRY_W-1:0]   in_wl;
  logic [ENTRY_W-1:0]   in_yl;
  logic [ENTRY_W-1:0]   in_qw;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[IDX_LSB +: INDEX_W];
  assign in_wl  = s_axis_tdata[WL_LSB  +: ENTRY_W];
  assign in_yl  = s_axis_tdata[YL_LSB  +: ENTRY_W];
  assign in_qw  = s_axis_tdata[QW_LSB  +: ENTRY_W];

  // registers
  state_t                    state, state_next;
  logic [LEN_W-1:0]          table_length;
  logic [ENTRY_W-1:0]        qw;
  logic [IDX_W-1:0]          lo, hi, mid;
  logic [ENTRY_W-1:0]        w0;
  logic signed [ENTRY_W-1:0] y0;
  logic signed [DIFF_W-1:0]  dq, dy, dw;
  logic [PROD_W-1:0]         prod;
  logic                      neg;
  logic                      dw_zero;
  logic [ENTRY_W-1:0]        dw_mag;
  logic signed [VAL_W-1:0]   val;
  logic                      out_valid;
  logic [RES_W-1:0]          out_res;

  // combinational
  logic                      in_xfer;
  logic                      out_free;
  logic                      span_gt1;
  logic [IDX_W:0]            mid_sum;
  logic [IDX_W-1:0]          mid_c;
  logic [IDX_W-1:0]          lo_inc;
  logic [NLEN_W-1:0]         len_ext;
  logic [NLEN_W-1:0]         n_eff;
  logic [NLEN_W-1:0]         n_m1;
  logic                      wr_en;
  logic [IDX_W-1:0]          rd_addr;
  logic [2*ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]        rd_wl;
  logic [ENTRY_W-1:0]        rd_yl;
  logic                      div_start;
  div_status_t               div_st;
  logic signed [VAL_W-1:0]   corr;
  logic [RES_W-1:0]          res_c;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign rd_wl    = rd_data[ENTRY_W-1:0];
  assign rd_yl    = rd_data[2*ENTRY_W-1:ENTRY_W];

  // effective table length, clamped to 2 .. TABLE_DEPTH
  always_comb begin
    len_ext = NLEN_W'(table_length);
    if (len_ext < N_MIN) begin
      n_eff = N_MIN;
    end else if (len_ext > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = len_ext;
    end
    n_m1 = n_eff - 1'b1;
  end

  // search helpers
  always_comb begin
    span_gt1 = (hi - lo) > IDX_W'(1);
    mid_sum  = {1'b0, lo} + {1'b0, hi};
    mid_c    = mid_sum[IDX_W:1];
    lo_inc   = lo + 1'b1;
  end

  // configuration register, no transfer while in reset
  assign cfg_ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_length <= cfg_data;
    end
  end

  // table load, slots past the depth are dropped
  assign wr_en = in_xfer && (in_op == OP_LOAD) &&
                 (32'(in_idx) < 32'(TABLE_DEPTH));

  tic_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_idx)),
    .wr_data ({in_yl, in_wl}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tic_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dw_mag),
    .status   (div_st)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_QUERY) state_next = ST_SEARCH;
      end
      ST_SEARCH:  state_next = span_gt1 ? ST_SWAIT : ST_RDHI;
      ST_SWAIT:   state_next = ST_SEARCH;
      ST_RDHI:    state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_MUL;
      ST_MUL:     state_next = ST_DIVGO;
      ST_DIVGO:   state_next = dw_zero ? ST_OUT : ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_st.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs, input held off while in reset
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    rd_addr       = lo_inc;
    case (state)
      ST_IDLE:   s_axis_tready = !rst;
      ST_SEARCH: rd_addr = span_gt1 ? mid_c : lo;
      ST_RDHI:   rd_addr = lo_inc;
      ST_DIVGO:  div_start = !dw_zero;
      default:   ;
    endcase
  end

  // signed correction from the divider
  always_comb begin
    corr = VAL_W'(div_st.quot);
    if (neg) corr = -corr;
  end

  // clamp to 0 .. 1.0
  always_comb begin
    if (val < 0) begin
      res_c = '0;
    end else if (val > VAL_ONE) begin
      res_c = RES_ONE;
    end else begin
      res_c = val[RES_W-1:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qw <= in_qw;
        lo <= '0;
        hi <= IDX_W'(n_m1);
      end
      ST_SEARCH: mid <= mid_c;
      ST_SWAIT: begin
        if (qw >= rd_wl) begin
          lo <= mid;
        end else begin
          hi <= mid;
        end
      end
      ST_RDHI: begin
        w0 <= rd_wl;
        y0 <= rd_yl;
      end
      ST_DIFF: begin
        dq <= $signed({1'b0, qw}) - $signed({1'b0, w0});
        dy <= $signed({rd_yl[ENTRY_W-1], rd_yl}) - $signed({y0[ENTRY_W-1], y0});
        dw <= $signed({1'b0, rd_wl}) - $signed({1'b0, w0});
      end
      ST_MUL: begin
        prod    <= PROD_W'(mag33(dq)) * PROD_W'(mag33(dy));
        dw_mag  <= mag33(dw);
        dw_zero <= (dw == '0);
        neg     <= dq[DIFF_W-1] ^ dy[DIFF_W-1] ^ dw[DIFF_W-1];
      end
      ST_DIVGO: begin
        if (dw_zero) val <= VAL_W'(y0);
      end
      ST_DIVWAIT: begin
        if (div_st.done) val <= VAL_W'(y0) + corr;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_res <= res_c;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_res);

endmodule
`default_nettype wire
